@@ hw/rtl/knt_pkg.sv @@
package knt_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_SAVE = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [63:0] device_id;
		logic [63:0] join_id;
		logic [63:0] key_high;
		logic [63:0] key_low;
		logic [31:0] nonce_in;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic        hit;
		logic [31:0] nonce_out;
		logic        changed;
		logic [31:0] generation_out;
	} rsp_t;

	typedef struct packed {
		logic [63:0] device_id;
		logic [63:0] join_id;
		logic [63:0] key_high;
		logic [63:0] key_low;
	} tag_t;

endpackage

@@ hw/rtl/keyed_nonce_table_core.sv @@
// Fully associative nonce table of knt_pkg::ENTRIES entries, each keyed by device id, join id
// and 128-bit key. One request is accepted per clock cycle while req_stall is low, and its
// response follows in order: the request is registered, then every valid entry is compared
// against it in parallel and the table update and response are registered together, so the
// next request already sees the updated table. While a response is stalled the table stage
// holds, and the input register still takes one request if it is empty. Entries are appended
// in order and never removed; a miss on a full table fails with ok low. The generation counter
// counts real changes and wraps.
module keyed_nonce_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  knt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output knt_pkg::rsp_t rsp
);

	logic                      valid_s1;
	knt_pkg::req_t             req_s1;
	logic                      rsp_valid_q;
	knt_pkg::rsp_t             rsp_q;
	logic [knt_pkg::CNT_W-1:0] count_q;
	logic [31:0]               gen_q;
	knt_pkg::tag_t             tag_q   [knt_pkg::ENTRIES];
	logic [31:0]               nonce_q [knt_pkg::ENTRIES];

	logic                      advance;
	logic                      load_s1;
	knt_pkg::tag_t             req_tag;
	logic [knt_pkg::ENTRIES-1:0] match;
	logic                      hit;
	logic [knt_pkg::IDX_W-1:0] hit_idx;
	logic [31:0]               hit_nonce;
	logic                      full;
	logic                      is_save;
	logic                      do_update;
	logic                      do_append;
	logic [knt_pkg::IDX_W-1:0] new_idx;
	logic [31:0]               gen_next;
	knt_pkg::rsp_t             rsp_next;

	assign advance   = !rsp_valid_q || !rsp_stall;
	// an empty input register can take a request even while the response is stalled
	assign load_s1   = advance || !valid_s1;
	assign req_stall = !load_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_tag = '{device_id: req_s1.device_id, join_id: req_s1.join_id,
		key_high: req_s1.key_high, key_low: req_s1.key_low};

	always_comb begin
		for (int i = 0; i < knt_pkg::ENTRIES; i++) begin
			match[i] = (knt_pkg::CNT_W'(i) < count_q) && (tag_q[i] == req_tag);
		end
	end

	// lowest matching index wins
	always_comb begin
		hit_idx = '0;
		for (int i = knt_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = knt_pkg::IDX_W'(i);
			end
		end
	end

	assign hit       = |match;
	assign hit_nonce = nonce_q[hit_idx];
	assign full      = (count_q == knt_pkg::CNT_W'(knt_pkg::ENTRIES));
	assign is_save   = (req_s1.req_type == knt_pkg::REQ_SAVE);
	assign do_update = is_save && hit && (hit_nonce != req_s1.nonce_in);
	assign do_append = is_save && !hit && !full;
	assign new_idx   = count_q[knt_pkg::IDX_W-1:0];
	assign gen_next  = (do_update || do_append) ? gen_q + 32'd1 : gen_q;

	always_comb begin
		rsp_next.ok             = hit || !full;
		rsp_next.hit            = hit;
		rsp_next.nonce_out      = (!is_save && hit) ? hit_nonce : 32'd0;
		rsp_next.changed        = do_update || do_append;
		rsp_next.generation_out = gen_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			gen_q       <= '0;
		end else begin
			if (load_s1) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
				if (valid_s1) begin
					gen_q <= gen_next;
					if (do_append) begin
						count_q <= count_q + knt_pkg::CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (advance) begin
			if (valid_s1) begin
				rsp_q <= rsp_next;
				if (do_update) begin
					nonce_q[hit_idx] <= req_s1.nonce_in;
				end
				if (do_append) begin
					tag_q[new_idx]   <= req_tag;
					nonce_q[new_idx] <= req_s1.nonce_in;
				end
			end
		end
	end

endmodule

@@ hw/rtl/keyed_nonce_table_checker.sv @@
module keyed_nonce_table_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input knt_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input knt_pkg::rsp_t rsp
);

	logic [31:0] last_gen_q;
	logic        rsp_take;

	assign rsp_take = rsp_valid && !rsp_stall;

	// generation seen in the last delivered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_gen_q <= '0;
		end else if (rsp_take) begin
			last_gen_q <= rsp.generation_out;
		end
	end

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && rsp.changed |-> rsp.generation_out == last_gen_q + 32'd1)
		else $error("generation did not step on a change");

	a_gen_keep: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_take && !rsp.changed |-> rsp.generation_out == last_gen_q)
		else $error("generation moved without a change");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.ok |-> !rsp.hit && !rsp.changed && rsp.nonce_out == 32'd0)
		else $error("failed request reported a hit or change");

endmodule

bind keyed_nonce_table_core keyed_nonce_table_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
